@@ design/c2d_pkg.sv @@
// Shared types and constants of the 3x3 streaming convolution.
// Pixel, line buffer word, window column and result item types,
// configuration register indexes. No dependencies.
package c2d_pkg;

	localparam int PIX_W      = 8;
	localparam int POS_W      = 11;
	localparam int DIM_W      = 12;
	localparam int VAL_W      = 28;
	localparam int SLOT_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int KSIZE      = 3;
	localparam int POS_LIMIT  = 2048;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BORDER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KTOP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KMID   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KBOT   = 3'd5;

	typedef logic [PIX_W-1:0] pix_t;

	// one line buffer entry: pixel two rows up and pixel one row up
	typedef struct packed {
		pix_t older;
		pix_t newer;
	} lb_word_t;

	// one window column, top to bottom
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} column_t;

	typedef struct packed {
		logic shift_en;
		logic acc_en;
	} cell_ctrl_t;

	// position and result flags of one accepted pixel
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             interior;
		logic             border;
		pix_t             bval;
	} item_t;

	// zero acts as one, anything above the limit acts as the limit
	function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = {{(DIM_W-1){1'b0}}, 1'b1};
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ design/c2d_linebuf.sv @@
// Line buffer memory: one entry per column holding the two previous rows.
// Registered read, one write port. Depends on c2d_pkg.
module c2d_linebuf #(
	parameter int DEPTH = 2048,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output c2d_pkg::lb_word_t rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  c2d_pkg::lb_word_t wr_data
);

	c2d_pkg::lb_word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read before write: a same-address write in this cycle is forwarded outside
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/c2d_cell.sv @@
// Window cell: holds one column of the 3x3 window, passes it to its left
// neighbor on each shift and forms the column's weighted sum. Depends on c2d_pkg.
module c2d_cell #(
	parameter int COEF_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  c2d_pkg::cell_ctrl_t             ctrl,
	input  c2d_pkg::column_t                col_in,
	output c2d_pkg::column_t                col_out,
	input  logic signed [COEF_BITS-1:0]     coef_top,
	input  logic signed [COEF_BITS-1:0]     coef_mid,
	input  logic signed [COEF_BITS-1:0]     coef_bot,
	output logic signed [COEF_BITS+10:0]    partial_s3
);

	localparam int PROD_W = COEF_BITS + 9;
	localparam int PART_W = COEF_BITS + 11;

	c2d_pkg::column_t          column_q;
	logic signed [PROD_W-1:0]  prod_top;
	logic signed [PROD_W-1:0]  prod_mid;
	logic signed [PROD_W-1:0]  prod_bot;
	logic signed [PART_W-1:0]  partial_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
		end else if (ctrl.shift_en) begin
			column_q <= col_in;
		end
	end

	assign col_out = column_q;

	always_comb begin
		prod_top  = $signed({1'b0, column_q.top}) * coef_top;
		prod_mid  = $signed({1'b0, column_q.mid}) * coef_mid;
		prod_bot  = $signed({1'b0, column_q.bot}) * coef_bot;
		partial_d = PART_W'(prod_top) + PART_W'(prod_mid) + PART_W'(prod_bot);
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_en) begin
			partial_s3 <= partial_d;
		end
	end

endmodule

@@ design/conv2d_3x3_stream_border.sv @@
// Streaming 3x3 correlation over 8-bit grey pixels in raster order, with border ring.
// Top level: configuration, position tracking, line buffer, window cells, result slot.
// Depends on c2d_pkg, c2d_linebuf, c2d_cell.
//
// Pixels enter one per clock. Each pixel gives zero, one or two results on one result
// port: a pixel in the border ring is answered at once (zero or its own value, by
// border_mode), and an interior pixel is answered when the pixel one row down and one
// column right arrives; when a pixel gives both, the interior result comes first. The
// single result port sets the rate: one pixel per clock while out_ready holds and each
// gives at most one result; a pixel that gives two stalls the input until its first is taken.
// The first result of a pixel passes through line buffer read, window shift, column products
// and final sum, one register each, the first loaded at the accepting edge; out_ready low stalls it.
// The two previous rows sit in one memory of MAX_WIDTH entries, read when a pixel is
// accepted and written when it leaves the first stage, with a bypass for back-to-back
// hits on the same column. The memory is not cleared after reset; the first two rows of
// a frame never use its contents. Width and height above their limit act as the limit,
// zero acts as one; frame_start restarts the position at row 0, column 0.
module conv2d_3x3_stream_border #(
	parameter int MAX_WIDTH = 2048,
	parameter int COEF_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [c2d_pkg::PIX_W-1:0]             pixel,
	input  logic                                  frame_start,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [c2d_pkg::POS_W-1:0]             out_row,
	output logic [c2d_pkg::POS_W-1:0]             out_col,
	output logic signed [c2d_pkg::VAL_W-1:0]      out_value,
	output logic                                  is_border,
	output logic                                  last_of_run,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [c2d_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WLIM   = (MAX_WIDTH < c2d_pkg::POS_LIMIT) ? MAX_WIDTH : c2d_pkg::POS_LIMIT;
	localparam int PART_W = COEF_BITS + 11;
	localparam int SUM_W  = COEF_BITS + 13;
	localparam int DIM_W  = c2d_pkg::DIM_W;
	localparam int POS_W  = c2d_pkg::POS_W;
	localparam int KSIZE  = c2d_pkg::KSIZE;

	localparam logic [DIM_W-1:0] WLIM_D  = DIM_W'(WLIM);
	localparam logic [DIM_W-1:0] HLIM_D  = DIM_W'(c2d_pkg::POS_LIMIT);
	localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);
	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
	localparam logic [POS_W-1:0] POS_TWO = POS_W'(2);

	// configuration
	logic [DIM_W-1:0]            w_eff_q;
	logic [DIM_W-1:0]            h_eff_q;
	logic                        border_mode_q;
	logic signed [COEF_BITS-1:0] kern_q [KSIZE][KSIZE];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q       <= c2d_pkg::eff_dim(c2d_pkg::WIDTH_RESET, WLIM_D);
			h_eff_q       <= c2d_pkg::eff_dim(c2d_pkg::HEIGHT_RESET, HLIM_D);
			border_mode_q <= 1'b0;
			for (int i = 0; i < KSIZE; i++) begin
				for (int j = 0; j < KSIZE; j++) begin
					kern_q[i][j] <= '0;
				end
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				c2d_pkg::CFG_WIDTH: begin
					w_eff_q <= c2d_pkg::eff_dim(cfg_data[DIM_W-1:0], WLIM_D);
				end
				c2d_pkg::CFG_HEIGHT: begin
					h_eff_q <= c2d_pkg::eff_dim(cfg_data[DIM_W-1:0], HLIM_D);
				end
				c2d_pkg::CFG_BORDER: begin
					border_mode_q <= cfg_data[0];
				end
				c2d_pkg::CFG_KTOP: begin
					for (int j = 0; j < KSIZE; j++) begin
						kern_q[0][j] <= cfg_data[c2d_pkg::SLOT_W*j +: COEF_BITS];
					end
				end
				c2d_pkg::CFG_KMID: begin
					for (int j = 0; j < KSIZE; j++) begin
						kern_q[1][j] <= cfg_data[c2d_pkg::SLOT_W*j +: COEF_BITS];
					end
				end
				c2d_pkg::CFG_KBOT: begin
					for (int j = 0; j < KSIZE; j++) begin
						kern_q[2][j] <= cfg_data[c2d_pkg::SLOT_W*j +: COEF_BITS];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	logic s1_v, s2_v, s3_v, o_v_q;
	logic s1_adv, s2_adv, s3_adv;
	logic o_int_q, o_bord_q;
	logic in_fire;

	assign s3_adv   = !o_v_q || (out_ready && !(o_int_q && o_bord_q));
	assign s2_adv   = !s3_v || s3_adv;
	assign s1_adv   = !s2_v || s2_adv;
	assign in_ready = !s1_v || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// position of the arriving pixel
	logic [POS_W-1:0] row_q, col_q;
	logic [POS_W-1:0] r0, c0, r_cur, c_cur;
	logic [DIM_W-1:0] r1, r_nx, c_nx;
	logic             cur_interior, cur_border;

	always_comb begin
		r0 = frame_start ? '0 : row_q;
		c0 = frame_start ? '0 : col_q;
		if ({1'b0, c0} >= w_eff_q) begin
			c_cur = '0;
			r1    = {1'b0, r0} + DIM_ONE;
		end else begin
			c_cur = c0;
			r1    = {1'b0, r0};
		end
		r_cur        = (r1 >= h_eff_q) ? '0 : r1[POS_W-1:0];
		c_nx         = {1'b0, c_cur} + DIM_ONE;
		r_nx         = {1'b0, r_cur} + DIM_ONE;
		cur_interior = (r_cur >= POS_TWO) && (c_cur >= POS_TWO);
		cur_border   = (r_cur == '0) || (c_cur == '0) || (r_nx >= h_eff_q) || (c_nx >= w_eff_q);
	end

	// advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			if (c_nx >= w_eff_q) begin
				col_q <= '0;
				row_q <= (r_nx >= h_eff_q) ? '0 : r_nx[POS_W-1:0];
			end else begin
				col_q <= c_nx[POS_W-1:0];
				row_q <= r_cur;
			end
		end
	end

	// stage 1: line buffer read in flight
	c2d_pkg::item_t    item_s1, item_s2, item_s3, item_q;
	c2d_pkg::pix_t     px_s1;
	logic              fwd_s1;
	c2d_pkg::lb_word_t fwd_data_s1;
	c2d_pkg::lb_word_t lb_rd, lb_eff, lb_wr;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic              lb_wr_en, lb_hit;

	assign rd_addr  = AW'(c_cur);
	assign wr_addr  = AW'(item_s1.col);
	assign lb_wr_en = s1_v && s1_adv;
	assign lb_eff   = fwd_s1 ? fwd_data_s1 : lb_rd;
	assign lb_wr    = '{older: lb_eff.newer, newer: px_s1};
	assign lb_hit   = lb_wr_en && (rd_addr == wr_addr);

	c2d_linebuf #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_linebuf (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (lb_rd),
		.wr_en   (lb_wr_en),
		.wr_addr (wr_addr),
		.wr_data (lb_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v     <= 1'b0;
			s2_v     <= 1'b0;
			s3_v     <= 1'b0;
			o_v_q    <= 1'b0;
			o_int_q  <= 1'b0;
			o_bord_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_v <= in_valid;
			end
			// drop pixels that give no result once they have updated the window
			if (s1_adv) begin
				s2_v <= s1_v && (item_s1.interior || item_s1.border);
			end
			if (s2_adv) begin
				s3_v <= s2_v;
			end
			if (s3_adv) begin
				o_v_q    <= s3_v;
				o_int_q  <= item_s3.interior;
				o_bord_q <= item_s3.border;
			end else if (out_valid && out_ready) begin
				o_int_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.row      <= r_cur;
			item_s1.col      <= c_cur;
			item_s1.interior <= cur_interior;
			item_s1.border   <= cur_border;
			item_s1.bval     <= border_mode_q ? pixel : '0;
			px_s1            <= pixel;
			// write of the previous pixel lands at this edge: bypass the memory
			fwd_s1           <= lb_hit;
			fwd_data_s1      <= lb_wr;
		end
		if (s1_adv) begin
			item_s2 <= item_s1;
		end
		if (s2_adv) begin
			item_s3 <= item_s2;
		end
		if (s3_adv) begin
			item_q <= item_s3;
		end
	end

	// stage 2 and 3: window cells, left to right
	c2d_pkg::cell_ctrl_t      cell_ctrl;
	c2d_pkg::column_t         new_col;
	c2d_pkg::column_t         col_in_w  [KSIZE];
	c2d_pkg::column_t         col_out_w [KSIZE];
	logic signed [PART_W-1:0] part_w    [KSIZE];

	assign cell_ctrl.shift_en = s1_v && s1_adv;
	assign cell_ctrl.acc_en   = s2_v && s2_adv;
	assign new_col            = '{top: lb_eff.older, mid: lb_eff.newer, bot: px_s1};

	for (genvar j = 0; j < KSIZE; j++) begin : g_cell
		if (j == KSIZE - 1) begin : g_right
			assign col_in_w[j] = new_col;
		end else begin : g_inner
			assign col_in_w[j] = col_out_w[j+1];
		end

		c2d_cell #(
			.COEF_BITS (COEF_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.col_in     (col_in_w[j]),
			.col_out    (col_out_w[j]),
			.coef_top   (kern_q[0][j]),
			.coef_mid   (kern_q[1][j]),
			.coef_bot   (kern_q[2][j]),
			.partial_s3 (part_w[j])
		);
	end

	logic signed [SUM_W-1:0]           sum_s3;
	logic signed [c2d_pkg::VAL_W-1:0]  sum_q;

	assign sum_s3 = SUM_W'(part_w[0]) + SUM_W'(part_w[1]) + SUM_W'(part_w[2]);

	always_ff @(posedge clk) begin
		if (s3_adv) begin
			sum_q <= c2d_pkg::VAL_W'(sum_s3);
		end
	end

	// result slot: interior result first, then border result
	assign out_valid   = o_v_q;
	assign is_border   = !o_int_q;
	assign last_of_run = !(o_int_q && o_bord_q);
	assign out_row     = o_int_q ? item_q.row - POS_ONE : item_q.row;
	assign out_col     = o_int_q ? item_q.col - POS_ONE : item_q.col;
	assign out_value   = o_int_q ? sum_q : $signed(c2d_pkg::VAL_W'(item_q.bval));

	a_slot_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		o_v_q |-> (o_int_q || o_bord_q))
		else $error("result slot valid with no pending result");

	a_s2_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v |-> (item_s2.interior || item_s2.border))
		else $error("pixel without result reached the product stage");

	a_interior_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_border) |-> (out_row != '0 && out_col != '0))
		else $error("interior result on the first row or column");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=>
		(out_valid && is_border && out_row == $past(out_row) + POS_ONE
			&& out_col == $past(out_col) + POS_ONE))
		else $error("border result does not follow its interior result");

endmodule
